### design/postfix_stack_evaluator_top_macros.svh
// ----------------------------------------------------------------------------
// postfix stack evaluator assertion macros
// concurrent assertion shorthands used by the checker
// ----------------------------------------------------------------------------
`ifndef POSTFIX_STACK_EVALUATOR_TOP_MACROS_SVH
`define POSTFIX_STACK_EVALUATOR_TOP_MACROS_SVH

// checked only while out of reset
`define PSE_ASSERT(name, clk, rst_n, prop) \
    name: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error("postfix stack evaluator assertion failed");

// checked on every edge, reset included
`define PSE_ASSERT_ALWAYS(name, clk, prop) \
    name: assert property (@(posedge clk) (prop)) \
        else $error("postfix stack evaluator assertion failed");

`endif

### design/pse_pkg.sv
// ----------------------------------------------------------------------------
// pse_pkg
// shared types, symbol codes and status codes of the postfix evaluator
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package pse_pkg;

    localparam int SYM_W       = 8;
    localparam int OUT_VALUE_W = 32;
    localparam int M_TDATA_W   = 40;

    localparam logic [SYM_W-1:0] SYM_PLUS   = 8'h2B;
    localparam logic [SYM_W-1:0] SYM_MINUS  = 8'h2D;
    localparam logic [SYM_W-1:0] SYM_STAR   = 8'h2A;
    localparam logic [SYM_W-1:0] SYM_SLASH  = 8'h2F;
    localparam logic [SYM_W-1:0] SYM_ZERO   = 8'h30;
    localparam logic [SYM_W-1:0] SYM_CARET  = 8'h5E;
    localparam logic [SYM_W-1:0] SYM_LPAREN = 8'h28;
    localparam logic [SYM_W-1:0] SYM_RPAREN = 8'h29;

    typedef enum logic [2:0] {
        ST_OK    = 3'd0,
        ST_UNDER = 3'd1,
        ST_OVER  = 3'd2,
        ST_DIVZ  = 3'd3,
        ST_UNSUP = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        CLS_PUSH,
        CLS_ADD,
        CLS_SUB,
        CLS_MUL,
        CLS_DIV,
        CLS_UNSUP
    } sym_class_t;

    typedef struct packed {
        logic load_in;
        logic start_arith;
        logic commit;
        logic report;
    } pse_cmd_t;

    typedef struct packed {
        sym_class_t sym_class;
        logic       last;
        logic       cnt_lt2;
        logic       right_zero;
        logic       arith_done;
        logic       out_free;
    } pse_stat_t;

    function automatic sym_class_t classify(input logic [SYM_W-1:0] sym);
        sym_class_t c;
        case (sym)
            SYM_PLUS:   c = CLS_ADD;
            SYM_MINUS:  c = CLS_SUB;
            SYM_STAR:   c = CLS_MUL;
            SYM_SLASH:  c = CLS_DIV;
            SYM_CARET:  c = CLS_UNSUP;
            SYM_LPAREN: c = CLS_UNSUP;
            SYM_RPAREN: c = CLS_UNSUP;
            default:    c = CLS_PUSH;
        endcase
        return c;
    endfunction

endpackage

### design/pse_arith.sv
// ----------------------------------------------------------------------------
// pse_arith
// iterative shift-add multiplier and restoring divider, one bit per cycle
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pse_arith #(
    parameter int VALUE_WIDTH = 32
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   start,
    input  logic                   is_div,
    input  logic [VALUE_WIDTH-1:0] left,
    input  logic [VALUE_WIDTH-1:0] right,
    output logic                   done,
    output logic [VALUE_WIDTH-1:0] result
);

    localparam int CNT_W = $clog2(VALUE_WIDTH);
    localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(VALUE_WIDTH - 1);

    typedef enum logic [1:0] {A_IDLE, A_RUN, A_FIN} arith_state_t;

    arith_state_t           state_reg;
    logic [CNT_W-1:0]       cnt_reg;
    logic                   div_reg;
    logic                   neg_reg;
    logic [VALUE_WIDTH-1:0] shf_reg;
    logic [VALUE_WIDTH-1:0] opd_reg;
    logic [VALUE_WIDTH-1:0] acc_reg;

    logic [VALUE_WIDTH-1:0] left_mag;
    logic [VALUE_WIDTH-1:0] right_mag;
    logic [VALUE_WIDTH-1:0] rem_sh;
    logic [VALUE_WIDTH:0]   diff;
    logic [VALUE_WIDTH-1:0] mul_add;

    always_comb begin
        left_mag  = left[VALUE_WIDTH-1] ? (~left + 1'b1) : left;
        right_mag = right[VALUE_WIDTH-1] ? (~right + 1'b1) : right;
        rem_sh    = {acc_reg[VALUE_WIDTH-2:0], shf_reg[VALUE_WIDTH-1]};
        diff      = {1'b0, rem_sh} - {1'b0, opd_reg};
        mul_add   = acc_reg + (shf_reg[0] ? opd_reg : '0);
    end

    assign done   = (state_reg == A_FIN);
    assign result = div_reg ? (neg_reg ? (~shf_reg + 1'b1) : shf_reg) : acc_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= A_IDLE;
            cnt_reg   <= '0;
        end else begin
            case (state_reg)
                A_IDLE: begin
                    if (start) begin
                        state_reg <= A_RUN;
                        cnt_reg   <= '0;
                        div_reg   <= is_div;
                        neg_reg   <= left[VALUE_WIDTH-1] ^ right[VALUE_WIDTH-1];
                        acc_reg   <= '0;
                        shf_reg   <= is_div ? left_mag : right;
                        opd_reg   <= is_div ? right_mag : left;
                    end
                end
                A_RUN: begin
                    if (div_reg) begin
                        acc_reg <= diff[VALUE_WIDTH] ? rem_sh : diff[VALUE_WIDTH-1:0];
                        shf_reg <= {shf_reg[VALUE_WIDTH-2:0], ~diff[VALUE_WIDTH]};
                    end else begin
                        acc_reg <= mul_add;
                        shf_reg <= {1'b0, shf_reg[VALUE_WIDTH-1:1]};
                        opd_reg <= {opd_reg[VALUE_WIDTH-2:0], 1'b0};
                    end
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == LAST_STEP) begin
                        state_reg <= A_FIN;
                    end
                end
                A_FIN: begin
                    state_reg <= A_IDLE;
                end
                default: begin
                    state_reg <= A_IDLE;
                end
            endcase
        end
    end

endmodule

### design/pse_datapath.sv
// ----------------------------------------------------------------------------
// pse_datapath
// operand stack memory, adder, arithmetic unit, status and output register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pse_datapath import pse_pkg::*; #(
    parameter int STACK_DEPTH = 16,
    parameter int VALUE_WIDTH = 32
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  pse_cmd_t               cmd,
    output pse_stat_t              stat,
    input  logic [SYM_W-1:0]       in_symbol,
    input  logic                   in_last,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [OUT_VALUE_W-1:0] out_value,
    output status_t                out_status
);

    localparam int CNT_W = $clog2(STACK_DEPTH + 1);
    localparam int IDX_W = $clog2(STACK_DEPTH);
    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(STACK_DEPTH);

    logic [VALUE_WIDTH-1:0] stack_mem [STACK_DEPTH];

    logic [SYM_W-1:0]       sym_reg;
    logic                   last_reg;
    logic [CNT_W-1:0]       cnt_reg;
    logic [CNT_W-1:0]       cnt_next;
    status_t                err_reg;
    status_t                err_next;
    logic [VALUE_WIDTH-1:0] top_reg;
    logic [VALUE_WIDTH-1:0] sec_reg;
    logic                   out_valid_reg;
    logic [OUT_VALUE_W-1:0] out_value_reg;
    status_t                out_status_reg;

    sym_class_t                    sym_class;
    logic                          cnt_lt2;
    logic                          right_zero;
    logic [CNT_W-1:0]              cnt_m1;
    logic [CNT_W-1:0]              cnt_m2;
    logic [VALUE_WIDTH-1:0]        digit;
    logic [VALUE_WIDTH-1:0]        arith_result;
    logic                          arith_done;
    logic                          wr_en;
    logic [IDX_W-1:0]              wr_idx;
    logic [VALUE_WIDTH-1:0]        wr_data;
    status_t                       flag_code;
    logic signed [VALUE_WIDTH-1:0] report_top;
    status_t                       report_status;

    assign sym_class  = classify(sym_reg);
    assign cnt_lt2    = (cnt_reg < CNT_W'(2));
    assign right_zero = (top_reg == '0);
    assign cnt_m1     = cnt_reg - CNT_W'(1);
    assign cnt_m2     = cnt_reg - CNT_W'(2);
    assign digit      = VALUE_WIDTH'(sym_reg) - VALUE_WIDTH'(SYM_ZERO);

    pse_arith #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_arith (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.start_arith),
        .is_div  (sym_class == CLS_DIV),
        .left    (sec_reg),
        .right   (top_reg),
        .done    (arith_done),
        .result  (arith_result)
    );

    always_comb begin
        wr_en     = 1'b0;
        wr_idx    = cnt_reg[IDX_W-1:0];
        wr_data   = digit;
        cnt_next  = cnt_reg;
        flag_code = ST_OK;
        if (cmd.commit) begin
            case (sym_class)
                CLS_ADD, CLS_SUB, CLS_MUL, CLS_DIV: begin
                    if (cnt_lt2) begin
                        flag_code = ST_UNDER;
                    end else begin
                        wr_en    = 1'b1;
                        wr_idx   = cnt_m2[IDX_W-1:0];
                        cnt_next = cnt_m1;
                        case (sym_class)
                            CLS_ADD: wr_data = sec_reg + top_reg;
                            CLS_SUB: wr_data = sec_reg - top_reg;
                            CLS_MUL: wr_data = arith_result;
                            default: begin
                                if (right_zero) begin
                                    wr_data   = '0;
                                    flag_code = ST_DIVZ;
                                end else begin
                                    wr_data = arith_result;
                                end
                            end
                        endcase
                    end
                end
                CLS_UNSUP: begin
                    flag_code = ST_UNSUP;
                end
                default: begin
                    if (cnt_reg >= DEPTH_CNT) begin
                        flag_code = ST_OVER;
                    end else begin
                        wr_en    = 1'b1;
                        cnt_next = cnt_reg + CNT_W'(1);
                    end
                end
            endcase
        end
        err_next = (err_reg == ST_OK) ? flag_code : err_reg;
        if (cmd.report) begin
            cnt_next = '0;
            err_next = ST_OK;
        end
    end

    always_comb begin
        report_top    = (cnt_reg == '0) ? '0 : top_reg;
        report_status = ((cnt_reg == '0) && (err_reg == ST_OK)) ? ST_UNDER : err_reg;
    end

    // stack memory with registered reads of top and next-to-top
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            stack_mem[wr_idx] <= wr_data;
        end
        top_reg <= stack_mem[cnt_m1[IDX_W-1:0]];
        sec_reg <= stack_mem[cnt_m2[IDX_W-1:0]];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg       <= '0;
            err_reg       <= ST_OK;
            out_valid_reg <= 1'b0;
        end else begin
            cnt_reg <= cnt_next;
            err_reg <= err_next;
            if (cmd.report) begin
                out_valid_reg <= 1'b1;
            end else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            sym_reg  <= in_symbol;
            last_reg <= in_last;
        end
        if (cmd.report) begin
            out_value_reg  <= OUT_VALUE_W'(report_top);
            out_status_reg <= report_status;
        end
    end

    always_comb begin
        stat.sym_class  = sym_class;
        stat.last       = last_reg;
        stat.cnt_lt2    = cnt_lt2;
        stat.right_zero = right_zero;
        stat.arith_done = arith_done;
        stat.out_free   = !out_valid_reg || out_ready;
    end

    assign out_valid  = out_valid_reg;
    assign out_value  = out_value_reg;
    assign out_status = out_status_reg;

endmodule

### design/pse_controller.sv
// ----------------------------------------------------------------------------
// pse_controller
// sequences one symbol at a time through execute, arithmetic if needed, commit and, on a last symbol, settle and report
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pse_controller import pse_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      in_valid,
    output logic      in_ready,
    input  pse_stat_t stat,
    output pse_cmd_t  cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_ARITH,
        S_COMMIT,
        S_SETTLE,
        S_REPORT
    } ctrl_state_t;

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    logic needs_arith;

    assign needs_arith = ((stat.sym_class == CLS_MUL) || (stat.sym_class == CLS_DIV))
                         && !stat.cnt_lt2
                         && !((stat.sym_class == CLS_DIV) && stat.right_zero);

    assign in_ready = (state_reg == S_IDLE);

    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (in_valid) begin
                    cmd.load_in = 1'b1;
                    state_next  = S_EXEC;
                end
            end
            S_EXEC: begin
                if (needs_arith) begin
                    cmd.start_arith = 1'b1;
                    state_next      = S_ARITH;
                end else begin
                    state_next = S_COMMIT;
                end
            end
            S_ARITH: begin
                if (stat.arith_done) begin
                    state_next = S_COMMIT;
                end
            end
            S_COMMIT: begin
                cmd.commit = 1'b1;
                state_next = stat.last ? S_SETTLE : S_IDLE;
            end
            // stack read registers catch up with the write
            S_SETTLE: begin
                state_next = S_REPORT;
            end
            S_REPORT: begin
                if (stat.out_free) begin
                    cmd.report = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

### design/postfix_stack_evaluator_top.sv
// push, add, subtract and rejected symbols run through execute and commit before the next symbol is accepted
// multiply and divide also wait in the arithmetic state for the bit-serial arithmetic unit
// operator underflow and divide by zero skip that unit
// a last symbol adds the settle and report states, plus any wait for an earlier result to be taken
// the result is registered in the report state, after the settle state; the next symbol may enter while it waits
// synchronous active-low reset clears control, stack count, status and m_tvalid
// ----------------------------------------------------------------------------
// postfix_stack_evaluator_top
// postfix expression evaluator with an operand stack, one symbol per transaction
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module postfix_stack_evaluator_top import pse_pkg::*; #(
    parameter int STACK_DEPTH = 16,
    parameter int VALUE_WIDTH = 32
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [SYM_W-1:0]     s_tdata,   // [7:0] symbol
    input  logic                 s_tlast,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata    // [31:0] value, [34:32] status, rest zero
);

    pse_cmd_t               cmd;
    pse_stat_t              stat;
    logic [OUT_VALUE_W-1:0] out_value;
    status_t                out_status;

    pse_controller u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    pse_datapath #(
        .STACK_DEPTH (STACK_DEPTH),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_dp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .stat       (stat),
        .in_symbol  (s_tdata),
        .in_last    (s_tlast),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_value  (out_value),
        .out_status (out_status)
    );

    assign m_tdata = M_TDATA_W'({out_status, out_value});

endmodule

### design/pse_checker.sv
// ----------------------------------------------------------------------------
// pse_checker
// port-level checks of the postfix evaluator, bound to the top level
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "postfix_stack_evaluator_top_macros.svh"

module pse_checker import pse_pkg::*; (
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_tvalid,
    input logic                 s_tready,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata
);

    `PSE_ASSERT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    `PSE_ASSERT(a_one_in_flight, aclk, aresetn, s_tvalid && s_tready |=> !s_tready)
    `PSE_ASSERT(a_status_code, aclk, aresetn, m_tvalid |-> (m_tdata[34:32] == ST_OK || m_tdata[34:32] == ST_UNDER || m_tdata[34:32] == ST_OVER || m_tdata[34:32] == ST_DIVZ || m_tdata[34:32] == ST_UNSUP))
    `PSE_ASSERT(a_pad_zero, aclk, aresetn, m_tvalid |-> m_tdata[39:35] == 5'd0)
    `PSE_ASSERT_ALWAYS(a_reset_clears_out, aclk, !aresetn |=> !m_tvalid)

endmodule

bind postfix_stack_evaluator_top pse_checker u_pse_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
